/* rtl/core/iir_direct_form_two_filter_top_macros.svh */
// Assertion helpers. The using module provides clock and reset.
`ifndef IIR_DIRECT_FORM_TWO_FILTER_TOP_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_TOP_MACROS_SVH

// Same-cycle implication.
`define IIRDF2_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IIRDF2_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/iirdf2_pkg.sv */
`timescale 1ns / 1ps
package iirdf2_pkg;

   localparam int COEF_WIDTH = 16;
   localparam int CNT_W      = $clog2(COEF_WIDTH);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DENOM_HI_W = 48;
   localparam int ORDER_W    = 3;

   localparam logic [CSR_DATA_W-1:0] NUMER_LO_RESET = 64'd8192; // b0 = 1.0

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORDER    = 3'd0,
      CSR_ENABLE   = 3'd1,
      CSR_NUMER_LO = 3'd2,
      CSR_NUMER_HI = 3'd3,
      CSR_DENOM_LO = 3'd4,
      CSR_DENOM_HI = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ASTART,
      S_AWAIT,
      S_WROUND,
      S_BSTART,
      S_BWAIT,
      S_YROUND,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic negate;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_sts_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } hist_ctl_type;

   // One Q3.13 field out of a packed 64-bit word, slot 0 lowest
   function automatic logic signed [COEF_WIDTH-1:0] coef_field(
      input logic [CSR_DATA_W-1:0] packed_word,
      input logic [1:0]            slot
   );
      logic signed [COEF_WIDTH-1:0] f;
      unique case (slot)
         2'd0: f = packed_word[15:0];
         2'd1: f = packed_word[31:16];
         2'd2: f = packed_word[47:32];
         2'd3: f = packed_word[63:48];
      endcase
      return f;
   endfunction

endpackage

/* rtl/core/iirdf2_if.sv */
`timescale 1ns / 1ps
interface iirdf2_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output op, output sample_in, input ready);
   modport sink   (input valid, input op, input sample_in, output ready);
endinterface

interface iirdf2_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

interface iirdf2_csr_if;
   import iirdf2_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/iirdf2_mac.sv */
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: one coefficient bit per cycle.
module iirdf2_mac #(
   parameter int ACC_W  = 44,
   parameter int WORD_W = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iirdf2_pkg::mac_ctl_type              ctl,
   input  logic signed [ACC_W-1:0]              acc_init,
   input  logic signed [iirdf2_pkg::COEF_WIDTH-1:0] coef,
   input  logic signed [WORD_W-1:0]             word,
   output iirdf2_pkg::mac_sts_type              sts,
   output logic signed [ACC_W-1:0]              acc
);
   import iirdf2_pkg::*;

   logic                    run_ff, run_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic [COEF_WIDTH-1:0]   mplier_ff, mplier_in;
   logic                    neg_ff, neg_in;
   logic signed [ACC_W-1:0] addend;
   logic                    last, sub;

   always_comb begin
      last   = run_ff && (cnt_ff == CNT_W'(COEF_WIDTH - 1));
      addend = mplier_ff[0] ? mcand_ff : '0;
      // top coefficient bit carries negative weight
      sub    = (cnt_ff == CNT_W'(COEF_WIDTH - 1)) ^ neg_ff;

      run_in    = run_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      neg_in    = neg_ff;

      if (ctl.load) begin
         acc_in = acc_init;
      end else if (run_ff) begin
         acc_in = sub ? (acc_ff - addend) : (acc_ff + addend);
      end

      if (ctl.start) begin
         run_in    = 1'b1;
         cnt_in    = '0;
         mcand_in  = {{(ACC_W - WORD_W){word[WORD_W-1]}}, word};
         mplier_in = coef;
         neg_in    = ctl.negate;
      end else if (run_ff) begin
         cnt_in    = cnt_ff + 1'b1;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         if (last) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      neg_ff    <= neg_in;
   end

   assign sts.busy = run_ff;
   assign sts.done = last;
   assign acc      = acc_ff;

endmodule

/* rtl/core/iirdf2_round.sv */
`timescale 1ns / 1ps
// Round half up at the binary point, then clip to OUT_W signed.
module iirdf2_round #(
   parameter int IN_W  = 44,
   parameter int OUT_W = 24,
   parameter int FRAC  = 13
) (
   input  logic signed [IN_W-1:0]  acc,
   output logic signed [OUT_W-1:0] value,
   output logic                    clipped
);
   localparam logic signed [IN_W-1:0] HALF =
      {{(IN_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
   localparam logic signed [IN_W-1:0] HI =
      {{(IN_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic signed [IN_W-1:0] LO =
      {{(IN_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

   logic signed [IN_W-1:0] rsum;
   logic signed [IN_W-1:0] q;

   always_comb begin
      rsum = acc + HALF;
      q    = rsum >>> FRAC;
      if (q > HI) begin
         value   = HI[OUT_W-1:0];
         clipped = 1'b1;
      end else if (q < LO) begin
         value   = LO[OUT_W-1:0];
         clipped = 1'b1;
      end else begin
         value   = q[OUT_W-1:0];
         clipped = 1'b0;
      end
   end

endmodule

/* rtl/core/iirdf2_hist.sv */
`timescale 1ns / 1ps
// Delay line w[1..MAX_ORDER]; shifts only taps up to the order in use.
module iirdf2_hist #(
   parameter int MAX_ORDER = 7,
   parameter int HIST_W    = 24,
   parameter int TAP_W     = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  iirdf2_pkg::hist_ctl_type ctl,
   input  logic [TAP_W-1:0]         n,
   input  logic signed [HIST_W-1:0] w0,
   input  logic [TAP_W-1:0]         rd_tap,
   output logic signed [HIST_W-1:0] rd_word
);
   import iirdf2_pkg::*;

   logic signed [HIST_W-1:0] hist_ff [1:MAX_ORDER];
   logic signed [HIST_W-1:0] hist_in [1:MAX_ORDER];

   always_comb begin
      for (int i = 1; i <= MAX_ORDER; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (ctl.clear) begin
         for (int i = 1; i <= MAX_ORDER; i++) begin
            hist_in[i] = '0;
         end
      end else if (ctl.shift) begin
         for (int i = 2; i <= MAX_ORDER; i++) begin
            if (TAP_W'(i) <= n) begin
               hist_in[i] = hist_ff[i-1];
            end
         end
         if (n != '0) begin
            hist_in[1] = w0;
         end
      end
   end

   always_comb begin
      rd_word = '0;
      for (int i = 1; i <= MAX_ORDER; i++) begin
         if (rd_tap == TAP_W'(i)) begin
            rd_word = hist_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= MAX_ORDER; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         for (int i = 1; i <= MAX_ORDER; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

endmodule

/* rtl/core/iir_direct_form_two_filter_top.sv */
`timescale 1ns / 1ps
// Direct Form II IIR filter, fixed point. A request with op 0 filters one
// sample: w0 = round(x - sum a[i]*w[i]) clipped to SAMPLE_WIDTH+8 bits, then
// y = round(sum b[i]*w[i], i = 0..n) clipped to SAMPLE_WIDTH bits, the delay
// line moves up by one tap and y is returned; saturated flags either clip.
// A request with op 1 zeroes the history and returns nothing. With the
// filter disabled the sample comes straight back and the history is kept.
// Coefficients are Q3.13 (8192 = 1.0): b0..b7 and a1..a7 packed up to four
// to a register, lowest slot in the low bits. All products run through one
// bit-serial multiply-accumulate that takes one coefficient bit per cycle.
// Filtering runs a start and a wait state for each a tap, rounds w0, runs
// the pair again for each b tap, then rounds y and emits it. Pass-through
// goes straight to emit; a clear is done on acceptance. The result sits in
// an output register, so a new request is taken while the previous result
// waits to be collected. Configuration registers may be written only while
// no request is in progress.
module iir_direct_form_two_filter_top #(
   parameter int MAX_ORDER      = 7,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 13
) (
   input  logic         clock,
   input  logic         reset,
   iirdf2_req_if.sink   req_bus,
   iirdf2_rsp_if.source rsp_bus,
   iirdf2_csr_if.sink   csr_bus
);
   import iirdf2_pkg::*;

`include "iir_direct_form_two_filter_top_macros.svh"

   localparam int HIST_W = SAMPLE_WIDTH + 8;
   localparam int ACC_W  = HIST_W + COEF_WIDTH + 4;
   localparam int TAP_W  = $clog2(MAX_ORDER + 1);

   // configuration registers
   logic [ORDER_W-1:0]    order_ff;
   logic                  enable_ff;
   logic [CSR_DATA_W-1:0] numer_lo_ff, numer_hi_ff, denom_lo_ff;
   logic [DENOM_HI_W-1:0] denom_hi_ff;

   // sequencer
   state_type                  state_ff, state_in;
   logic [TAP_W-1:0]           tap_ff, tap_in;
   logic [TAP_W-1:0]           n_ff, n_in, n_req;
   logic signed [HIST_W-1:0]   w0_ff, w0_in;
   logic                       satw_ff, satw_in;
   logic signed [SAMPLE_WIDTH-1:0] res_ff, res_in;
   logic                       ressat_ff, ressat_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   mac_ctl_type                mac_ctl;
   mac_sts_type                mac_sts;
   hist_ctl_type               hist_ctl;
   logic signed [ACC_W-1:0]    acc_init, acc;
   logic signed [COEF_WIDTH-1:0] coef_a, coef_b, mac_coef;
   logic signed [HIST_W-1:0]   hist_rd, mac_word;
   logic signed [HIST_W-1:0]   w_round;
   logic signed [SAMPLE_WIDTH-1:0] y_round;
   logic                       w_clip, y_clip;
   logic [2:0]                 cidx, aslot;
   logic                       req_fire;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

   // order beyond the delay line depth is taken as the full depth
   assign n_req = (int'(order_ff) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : TAP_W'(order_ff);

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= '0;
         enable_ff   <= 1'b0;
         numer_lo_ff <= NUMER_LO_RESET;
         numer_hi_ff <= '0;
         denom_lo_ff <= '0;
         denom_hi_ff <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_ORDER:    order_ff    <= csr_bus.data[ORDER_W-1:0];
            CSR_ENABLE:   enable_ff   <= csr_bus.data[0];
            CSR_NUMER_LO: numer_lo_ff <= csr_bus.data;
            CSR_NUMER_HI: numer_hi_ff <= csr_bus.data;
            CSR_DENOM_LO: denom_lo_ff <= csr_bus.data;
            CSR_DENOM_HI: denom_hi_ff <= csr_bus.data[DENOM_HI_W-1:0];
            default: ; // unused indexes ignored
         endcase
      end
   end

   // ---- coefficient and operand selection ----
   always_comb begin
      cidx   = 3'(tap_ff);
      aslot  = cidx - 3'd1;   // a1 sits in slot 0
      coef_b = cidx[2] ? coef_field(numer_hi_ff, cidx[1:0])
                       : coef_field(numer_lo_ff, cidx[1:0]);
      coef_a = aslot[2] ? coef_field({{(CSR_DATA_W - DENOM_HI_W){1'b0}}, denom_hi_ff},
                                     aslot[1:0])
                        : coef_field(denom_lo_ff, aslot[1:0]);
      mac_coef = (state_ff == S_ASTART) ? coef_a : coef_b;
      // tap 0 of the numerator pass is the fresh w0
      mac_word = (tap_ff == '0) ? w0_ff : hist_rd;
      acc_init = (state_ff == S_IDLE)
         ? ({{(ACC_W - SAMPLE_WIDTH){req_bus.sample_in[SAMPLE_WIDTH-1]}},
             req_bus.sample_in} <<< COEF_FRAC_BITS)
         : '0;
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_ff      <= tap_in;
      n_ff        <= n_in;
      w0_ff       <= w0_in;
      satw_ff     <= satw_in;
      res_ff      <= res_in;
      ressat_ff   <= ressat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      n_in         = n_ff;
      w0_in        = w0_ff;
      satw_in      = satw_ff;
      res_in       = res_ff;
      ressat_in    = ressat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      mac_ctl      = '0;
      hist_ctl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.op) begin
                  hist_ctl.clear = 1'b1;
               end else if (!enable_ff) begin
                  res_in    = req_bus.sample_in;
                  ressat_in = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  mac_ctl.load = 1'b1;       // acc = x scaled to Q.13
                  n_in         = n_req;
                  tap_in       = TAP_W'(1);
                  state_in     = (n_req == '0) ? S_WROUND : S_ASTART;
               end
            end
         end
         S_ASTART: begin
            mac_ctl.start  = 1'b1;
            mac_ctl.negate = 1'b1;
            state_in       = S_AWAIT;
         end
         S_AWAIT: begin
            if (mac_sts.done) begin
               if (tap_ff == n_ff) begin
                  state_in = S_WROUND;
               end else begin
                  tap_in   = tap_ff + 1'b1;
                  state_in = S_ASTART;
               end
            end
         end
         S_WROUND: begin
            w0_in        = w_round;
            satw_in      = w_clip;
            mac_ctl.load = 1'b1;             // clear for the numerator pass
            tap_in       = '0;
            state_in     = S_BSTART;
         end
         S_BSTART: begin
            mac_ctl.start = 1'b1;
            state_in      = S_BWAIT;
         end
         S_BWAIT: begin
            if (mac_sts.done) begin
               if (tap_ff == n_ff) begin
                  state_in = S_YROUND;
               end else begin
                  tap_in   = tap_ff + 1'b1;
                  state_in = S_BSTART;
               end
            end
         end
         S_YROUND: begin
            res_in         = y_round;
            ressat_in      = satw_ff | y_clip;
            hist_ctl.shift = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_sat_in   = ressat_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // ---- datapath units ----
   iirdf2_mac #(
      .ACC_W  (ACC_W),
      .WORD_W (HIST_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .acc_init (acc_init),
      .coef     (mac_coef),
      .word     (mac_word),
      .sts      (mac_sts),
      .acc      (acc)
   );

   iirdf2_hist #(
      .MAX_ORDER (MAX_ORDER),
      .HIST_W    (HIST_W),
      .TAP_W     (TAP_W)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hist_ctl),
      .n       (n_ff),
      .w0      (w0_ff),
      .rd_tap  (tap_ff),
      .rd_word (hist_rd)
   );

   iirdf2_round #(
      .IN_W  (ACC_W),
      .OUT_W (HIST_W),
      .FRAC  (COEF_FRAC_BITS)
   ) u_round_w (
      .acc     (acc),
      .value   (w_round),
      .clipped (w_clip)
   );

   iirdf2_round #(
      .IN_W  (ACC_W),
      .OUT_W (SAMPLE_WIDTH),
      .FRAC  (COEF_FRAC_BITS)
   ) u_round_y (
      .acc     (acc),
      .value   (y_round),
      .clipped (y_clip)
   );

   // ---- checks ----
   `IIRDF2_ASSERT_NOW(a_done_in_wait, mac_sts.done, (state_ff == S_AWAIT) || (state_ff == S_BWAIT), "multiply finished outside a wait state")
   `IIRDF2_ASSERT_NOW(a_tap_bound, (state_ff != S_IDLE) && (state_ff != S_EMIT) && (state_ff != S_WROUND), tap_ff <= n_ff, "tap index beyond order")
   `IIRDF2_ASSERT_NEXT(a_clear_stays_idle, req_fire && req_bus.op, state_ff == S_IDLE, "clear request left idle")
   `IIRDF2_ASSERT_NEXT(a_bypass_emit, req_fire && !req_bus.op && !enable_ff, state_ff == S_EMIT, "pass-through did not go to emit")

endmodule

/* tb/iirdf2_filter_scoreboard.sv */
`timescale 1ns / 1ps
module iirdf2_filter_scoreboard import iirdf2_pkg::*; #(
   parameter int MAX_ORDER      = 7,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_op,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_sample,
   input  logic                           rsp_saturated,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data,
   output int                             fail_count,
   output int                             outstanding,
   output int                             results_checked
);

   localparam int     HIST_W     = SAMPLE_WIDTH + 8;
   localparam longint HIST_MAX   = (longint'(1) << (HIST_W - 1)) - 1;
   localparam longint HIST_MIN   = -HIST_MAX - 1;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           saturated;
   } filter_output_type;

   filter_output_type awaited_outputs [$];
   filter_output_type head;

   // shadow of the register file and the delay line
   logic [ORDER_W-1:0]           order_reg;
   logic                         enable_reg;
   logic [CSR_DATA_W-1:0]        numer_lo;
   logic [CSR_DATA_W-1:0]        numer_hi;
   logic [CSR_DATA_W-1:0]        denom_lo;
   logic [DENOM_HI_W-1:0]        denom_hi;
   logic signed [HIST_W-1:0]     delay_line [1:MAX_ORDER];

   // b0..b7; anything past the packed words reads as zero
   function automatic longint numer_tap(int i);
      logic [CSR_DATA_W-1:0] word;
      if (i >= 8) return 0;
      word = (i < 4) ? numer_lo : numer_hi;
      return longint'($signed(word[COEF_WIDTH*(i%4) +: COEF_WIDTH]));
   endfunction

   // a1..a7; the high word only holds three slots
   function automatic longint denom_tap(int i);
      logic [CSR_DATA_W-1:0] word;
      if (i < 1 || i > 7) return 0;
      word = (i <= 4) ? denom_lo : {{(CSR_DATA_W-DENOM_HI_W){1'b0}}, denom_hi};
      return longint'($signed(word[COEF_WIDTH*((i-1)%4) +: COEF_WIDTH]));
   endfunction

   // floor((v + half) / 2^frac): halves go up
   function automatic longint round_q(longint v);
      return (v + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   endfunction

   task automatic apply_filter_request(input logic op,
                                       input logic signed [SAMPLE_WIDTH-1:0] x);
      longint            acc;
      longint            w0;
      longint            y;
      logic              clipped;
      int                n;
      filter_output_type res;
      if (op) begin
         foreach (delay_line[i]) delay_line[i] = '0;
         return;
      end
      if (!enable_reg) begin
         res.sample_out = x;
         res.saturated  = 1'b0;
         awaited_outputs.push_back(res);
         return;
      end
      clipped = 1'b0;
      n = (int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
      acc = longint'(x) << COEF_FRAC_BITS;
      for (int i = 1; i <= n; i++) acc -= denom_tap(i) * longint'(delay_line[i]);
      w0 = round_q(acc);
      if (w0 > HIST_MAX) begin
         w0 = HIST_MAX; clipped = 1'b1;
      end else if (w0 < HIST_MIN) begin
         w0 = HIST_MIN; clipped = 1'b1;
      end
      acc = numer_tap(0) * w0;
      for (int i = 1; i <= n; i++) acc += numer_tap(i) * longint'(delay_line[i]);
      y = round_q(acc);
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX; clipped = 1'b1;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN; clipped = 1'b1;
      end
      // only taps 1..n move
      for (int i = n; i > 1; i--) delay_line[i] = delay_line[i-1];
      if (n >= 1) delay_line[1] = w0[HIST_W-1:0];
      res.sample_out = y[SAMPLE_WIDTH-1:0];
      res.saturated  = clipped;
      awaited_outputs.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         order_reg  = '0;
         enable_reg = 1'b0;
         numer_lo   = NUMER_LO_RESET;
         numer_hi   = '0;
         denom_lo   = '0;
         denom_hi   = '0;
         foreach (delay_line[i]) delay_line[i] = '0;
         awaited_outputs.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outputs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, actual sample %0d sat %0b",
                        $time, rsp_sample, rsp_saturated);
            end else begin
               head = awaited_outputs.pop_front();
               results_checked++;
               if (rsp_sample !== head.sample_out) begin
                  fail_count++;
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, head.sample_out, rsp_sample);
               end
               if (rsp_saturated !== head.saturated) begin
                  fail_count++;
                  $display("%0t: saturated mismatch: expected %0b, actual %0b",
                           $time, head.saturated, rsp_saturated);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORDER:    order_reg  = csr_data[ORDER_W-1:0];
               CSR_ENABLE:   enable_reg = csr_data[0];
               CSR_NUMER_LO: numer_lo   = csr_data;
               CSR_NUMER_HI: numer_hi   = csr_data;
               CSR_DENOM_LO: denom_lo   = csr_data;
               CSR_DENOM_HI: denom_hi   = csr_data[DENOM_HI_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) apply_filter_request(req_op, req_sample);
      end
      outstanding = awaited_outputs.size();
   end

endmodule

/* tb/tb_iir_direct_form_two_filter_top.sv */
`timescale 1ns / 1ps
module tb_iir_direct_form_two_filter_top;
   import iirdf2_pkg::*;

   localparam int MAX_ORDER      = 7;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 13;

   // The slowest request is at order 7; drain comfortably past it.
   localparam int DRAIN_CYCLES    = 300;
   localparam int LIMIT_CYCLES    = 2_000_000;
   localparam int IDLE_PERCENT    = 18;
   localparam int HOLD_CYCLES     = 600;
   localparam int RANDOM_PHASES   = 14;
   localparam int ITEMS_PER_PHASE = 56;
   localparam int STEADY_PHASE    = 2;   // no idling on either side
   localparam int HOLD_PHASE      = 5;   // receiver backs off for a long while

   // Indexes past the register list; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Coefficient generation styles
   localparam int unsigned STYLE_FULL    = 0;
   localparam int unsigned STYLE_SMALL   = 1;
   localparam int unsigned STYLE_EXTREME = 2;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   logic clock;
   logic reset;

   iirdf2_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_bus ();
   iirdf2_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_bus ();
   iirdf2_csr_if                                csr_bus ();

   int          fail_count;
   int          outstanding;
   int          results_checked;
   int unsigned cycle_count;
   int          requests_sent;
   int          clears_sent;
   int          settings_applied;
   logic        steady;        // suppresses random idling on both sides
   logic        hold_off_req;  // asks the receiver for a long stall

   iir_direct_form_two_filter_top #(
      .MAX_ORDER      (MAX_ORDER),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   iirdf2_filter_scoreboard #(
      .MAX_ORDER      (MAX_ORDER),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_op          (req_bus.op),
      .req_sample      (req_bus.sample_in),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_sample      (rsp_bus.sample_out),
      .rsp_saturated   (rsp_bus.saturated),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_bus.ready),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) cycle_count++;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result receiver. Ready moves on the falling edge only. A hold-off
   // request holds ready low for HOLD_CYCLES, counted here, while the
   // sender keeps offering requests so the output register and the input
   // side both back up.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Register write. Called at a falling edge, returns at a falling edge
   // with valid low, so back-to-back writes never toggle valid in one step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one request, with an optional random gap first. Valid stays
   // high into the next request when no gap is taken.
   task automatic send_request(input logic op,
                               input logic signed [SAMPLE_WIDTH-1:0] sample);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.sample_in <= sample;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if (op == OP_CLEAR) clears_sent++;
   endtask

   // Drop valid, wait for every awaited result, then let a clear (which
   // returns nothing) run out before the registers are touched.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_coef_word(int unsigned style,
                                                              int unsigned span);
      logic [CSR_DATA_W-1:0] word;
      logic [COEF_WIDTH-1:0] field;
      word = '0;
      for (int s = 0; s < 4; s++) begin
         case (style)
            STYLE_SMALL:
               field = COEF_WIDTH'(int'($urandom_range(2 * span)) - int'(span));
            STYLE_EXTREME:
               case ($urandom_range(3))
                  0:       field = 16'h7FFF;
                  1:       field = 16'h8000;
                  2:       field = 16'h0000;
                  default: field = 16'hFFFF;
               endcase
            default:
               field = COEF_WIDTH'($urandom);
         endcase
         word[COEF_WIDTH*s +: COEF_WIDTH] = field;
      end
      return word;
   endfunction

   // Mostly gentle coefficients so the filter does real work rather than
   // sitting on a rail; the rest are fully random or at the extremes.
   function automatic int unsigned pick_style();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return STYLE_SMALL;
      if (r < 85) return STYLE_FULL;
      return STYLE_EXTREME;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)  return 16'sh7FFF;
      if (r < 10) return 16'sh8000;
      return SAMPLE_WIDTH'($urandom);
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] data;
      int unsigned           pick;
      logic                  op;

      // every input known from time zero
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_FILTER;
      req_bus.sample_in = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ORDER;
      csr_bus.data      = '0;
      steady            = 1'b0;
      hold_off_req      = 1'b0;
      requests_sent     = 0;
      clears_sent       = 0;
      settings_applied  = 1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- Directed ---
      // Reset settings: filter off, so samples come straight back;
      // a clear while disabled returns nothing.
      send_request(OP_FILTER, 16'sh7FFF);
      send_request(OP_FILTER, 16'sh8000);
      send_request(OP_FILTER, 16'sh0000);
      send_request(OP_FILTER, -16'sd1);
      send_request(OP_CLEAR,  random_sample());
      wait_idle();

      // Full order, largest and smallest b, all-ones a. Spare upper bits
      // of order, enable and the short denominator word must be dropped.
      write_csr(CSR_ORDER,    64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_ENABLE,   64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_NUMER_LO, 64'h7FFF_7FFF_7FFF_7FFF);
      write_csr(CSR_NUMER_HI, 64'h8000_8000_8000_8000);
      write_csr(CSR_DENOM_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_DENOM_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      settings_applied++;
      send_request(OP_FILTER, 16'sh7FFF);
      send_request(OP_FILTER, 16'sh7FFF);
      send_request(OP_FILTER, 16'sh8000);
      send_request(OP_FILTER, 16'sh8000);
      send_request(OP_FILTER, 16'sh7FFF);
      send_request(OP_FILTER, 16'sh0000);
      wait_idle();

      // Order 2 with a = -4.0 drives the history onto its rails; taps
      // above 2 must keep what they held.
      write_csr(CSR_ORDER,    64'd2);
      write_csr(CSR_DENOM_LO, 64'h8000_8000_8000_8000);
      settings_applied++;
      send_request(OP_FILTER, 16'sh7FFF);
      send_request(OP_FILTER, 16'sh8000);
      send_request(OP_FILTER, 16'sd1234);
      wait_idle();

      // Back to order 7 with a = 0 and b = 1.0: the output sums the whole
      // delay line, so stale upper taps show up. Then clear while enabled.
      write_csr(CSR_ORDER,    64'd7);
      write_csr(CSR_NUMER_LO, 64'h2000_2000_2000_2000);
      write_csr(CSR_NUMER_HI, 64'h2000_2000_2000_2000);
      write_csr(CSR_DENOM_LO, 64'h0);
      write_csr(CSR_DENOM_HI, 64'h0);
      settings_applied++;
      send_request(OP_FILTER, 16'sd1);
      send_request(OP_FILTER, 16'sd0);
      send_request(OP_CLEAR,  random_sample());
      send_request(OP_FILTER, 16'sd100);
      wait_idle();

      // Writes past the register list change nothing
      write_csr(CSR_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_SPARE_HI, 64'h0000_0000_0000_0003);
      send_request(OP_FILTER, -16'sd100);
      wait_idle();

      // --- Random phases ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase == STEADY_PHASE);

         pick = $urandom_range(99);
         data = {$urandom, $urandom};
         if (pick < 10)      data[ORDER_W-1:0] = 3'd0;
         else if (pick < 30) data[ORDER_W-1:0] = 3'd7;
         write_csr(CSR_ORDER, data);
         data = {$urandom, $urandom};
         data[0] = ($urandom_range(99) < 88);
         write_csr(CSR_ENABLE,   data);
         write_csr(CSR_NUMER_LO, random_coef_word(pick_style(), 4096));
         write_csr(CSR_NUMER_HI, random_coef_word(pick_style(), 4096));
         write_csr(CSR_DENOM_LO, random_coef_word(pick_style(), 1500));
         write_csr(CSR_DENOM_HI, random_coef_word(pick_style(), 1500));
         if ($urandom_range(3) == 0)
            write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, {$urandom, $urandom});
         settings_applied++;

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (phase == HOLD_PHASE && k == 8) hold_off_req = 1'b1;
            op = ($urandom_range(99) < 6) ? OP_CLEAR : OP_FILTER;
            send_request(op, random_sample());
         end
         wait_idle();
      end
      steady = 1'b0;

      $display("covered %0d requests (%0d clears) over %0d register settings",
               requests_sent, clears_sent, settings_applied);
      $display("%0d results compared, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* iir_direct_form_two_filter_top.f */
+incdir+rtl/core
rtl/core/iirdf2_pkg.sv
rtl/core/iirdf2_if.sv
rtl/core/iirdf2_mac.sv
rtl/core/iirdf2_round.sv
rtl/core/iirdf2_hist.sv
rtl/core/iir_direct_form_two_filter_top.sv
tb/iirdf2_filter_scoreboard.sv
tb/tb_iir_direct_form_two_filter_top.sv
